>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helper macros for concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/ckfp_pkg.sv
// ----------------------------------------------------------------------------
// ckfp_pkg
// types, constants and the class table of the k-mer frequency profile
// ----------------------------------------------------------------------------
package ckfp_pkg;

    localparam int MER_LEN      = 4;
    localparam int CLASS_COUNT  = 180;
    localparam int CLASS_BITS   = 8;
    localparam int SLOTS        = 340;
    localparam int SLOT_BITS    = 9;
    localparam int LEN_BITS     = 2;
    localparam int CNT_W        = 20;
    localparam int FRAC_W       = 16;
    localparam int FREQ_W       = FRAC_W + 1;
    localparam int DIV_STEPS    = CNT_W + FRAC_W;
    localparam int STEP_BITS    = 6;
    localparam int HIST_BITS    = 2 * (MER_LEN - 1);
    localparam int RUN_BITS     = 3;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_CLEAR,
        ST_READ,
        ST_DIVIDE,
        ST_OUTPUT
    } ckfp_state_t;

    // controller to datapath
    typedef struct packed {
        logic       load;        // capture input word
        logic       count_step;  // update one length bank, index in len
        logic [1:0] len;
        logic       clear_step;  // zero all count entries, totals and history
        logic       read;        // read count and total for query
        logic       div_start;
        logic       div_step;
        logic       out_load;
    } ckfp_cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic       div_done;
        logic       mer_ok;      // current len window valid
    } ckfp_stat_t;

    function automatic logic [SLOT_BITS-1:0] slot_base(input int k);
        return SLOT_BITS'(((1 << (2 * k)) - 4) / 3);
    endfunction

    function automatic logic [7:0] rev_comp(input logic [7:0] m, input int k);
        logic [7:0] r;
        logic [7:0] x;
        r = '0;
        x = m;
        for (int i = 0; i < k; i++) begin
            r = {r[5:0], 2'd3 - x[1:0]};
            x = x >> 2;
        end
        return r;
    endfunction

    // class number of each mer slot, built at elaboration
    typedef logic [CLASS_BITS-1:0] class_tab_t [SLOTS];
    function automatic class_tab_t build_tab();
        class_tab_t t;
        int nxt;
        int b;
        int r;
        nxt = 0;
        t = '{default: '0};
        for (int k = 1; k <= MER_LEN; k++) begin
            b = ((1 << (2 * k)) - 4) / 3;
            for (int m = 0; m < (1 << (2 * k)); m++) begin
                r = int'(rev_comp(8'(m), k));
                if (r < m) begin
                    t[b + m] = t[b + r];
                end else begin
                    t[b + m] = CLASS_BITS'(nxt);
                    nxt++;
                end
            end
        end
        return t;
    endfunction

    localparam class_tab_t CLASS_TAB = build_tab();

    // length of a class index, 0 based
    function automatic logic [LEN_BITS-1:0] class_len(input logic [CLASS_BITS-1:0] c);
        if (c < 8'd2) begin
            return 2'd0;
        end else if (c < 8'd12) begin
            return 2'd1;
        end else if (c < 8'd44) begin
            return 2'd2;
        end
        return 2'd3;
    endfunction

endpackage

>>> design/ckfp_ctrl.sv
// ----------------------------------------------------------------------------
// ckfp_ctrl
// sequencer: one length bank per cycle on push, clear all on clear, divide on query
// ----------------------------------------------------------------------------
module ckfp_ctrl import ckfp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_func,
    output logic       out_valid,
    input  logic       out_ready,
    input  ckfp_stat_t stat,
    output ckfp_cmd_t  cmd
);

    ckfp_state_t state_reg, state_next;
    logic [1:0]  len_reg, len_next;
    logic        ovalid_reg, ovalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            len_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        cmd.len     = len_reg;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    len_next = '0;
                    unique case (in_func)
                        FUNC_PUSH:  state_next = ST_COUNT;
                        FUNC_QUERY: state_next = ST_READ;
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_COUNT: begin
                cmd.count_step = 1'b1;
                len_next = len_reg + 2'd1;
                if (len_reg == 2'(MER_LEN - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.read = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (stat.div_done) begin
                    state_next = ST_OUTPUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
                cmd.div_start = 1'b0;
            end
            ST_OUTPUT: begin
                if (!ovalid_reg || out_ready) begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> design/ckfp_datapath.sv
// ----------------------------------------------------------------------------
// ckfp_datapath
// count memory, length totals, history and restoring divider
// ----------------------------------------------------------------------------
module ckfp_datapath import ckfp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ckfp_cmd_t             cmd,
    output ckfp_stat_t            stat,
    input  logic [2:0]            in_base,
    input  logic [CLASS_BITS-1:0] in_class,
    output logic [FREQ_W-1:0]     frequency,
    output logic [CNT_W-1:0]      class_count,
    output logic [CNT_W-1:0]      length_total
);

    localparam logic [CNT_W-1:0] CMAX = '1;

    // count store, valid bits give the cleared value
    logic [CNT_W-1:0]      mem [CLASS_COUNT];
    logic [CLASS_COUNT-1:0] vld_reg;
    logic [CNT_W-1:0]      tot_reg [MER_LEN];
    logic [HIST_BITS-1:0]  hist_reg;
    logic [RUN_BITS-1:0]   run_reg;
    logic [7:0]            win_reg;
    logic                  ok_reg;
    logic [CLASS_BITS-1:0] qcls_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      qtot_reg;
    logic                  inrange_reg;
    logic [CNT_W-1:0]      rd_reg;
    logic [CNT_W:0]        rem_reg;
    logic [DIV_STEPS-1:0]  quo_reg;
    logic [DIV_STEPS-1:0]  numer_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [FREQ_W-1:0]     freq_reg;
    logic [CNT_W-1:0]      ocnt_reg, otot_reg;
    logic [CNT_W-1:0]      rdm_reg;
    logic                  rdv_reg;
    logic [CLASS_BITS-1:0] wcls_reg;
    logic                  wen_reg;

    logic [7:0]            mer;
    logic [SLOT_BITS-1:0]  slot;
    logic [CLASS_BITS-1:0] cls;
    logic [CNT_W-1:0]      cur;
    logic [CNT_W:0]        trial;
    logic [1:0]            qlen;

    always_comb begin
        unique case (cmd.len)
            2'd0:    mer = {6'd0, win_reg[1:0]};
            2'd1:    mer = {4'd0, win_reg[3:0]};
            2'd2:    mer = {2'd0, win_reg[5:0]};
            default: mer = win_reg;
        endcase
        slot = slot_base(int'(cmd.len) + 1) + SLOT_BITS'(mer);
        cls  = CLASS_TAB[slot];
    end

    // one bank per cycle: read a class, write it back the next cycle
    // classes of different lengths never collide so read-modify-write is safe
    assign cur = rdv_reg ? rdm_reg : '0;
    assign stat.mer_ok = ok_reg && (run_reg >= RUN_BITS'(cmd.len));
    assign stat.clear_done = 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.count_step) begin
            rdm_reg  <= mem[cls];
            rdv_reg  <= vld_reg[cls];
            wcls_reg <= cls;
        end
        if (wen_reg) begin
            mem[wcls_reg] <= (cur != CMAX) ? cur + CNT_W'(1) : cur;
        end
        if (cmd.read) begin
            rd_reg <= vld_reg[qcls_reg] ? mem[qcls_reg] : '0;
        end
    end

    assign qlen  = class_len(qcls_reg);
    assign trial = {rem_reg[CNT_W-1:0], numer_reg[DIV_STEPS-1]} - {1'b0, qtot_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            hist_reg <= '0;
            run_reg  <= '0;
            ok_reg   <= 1'b0;
            step_reg <= '0;
            wen_reg  <= 1'b0;
            for (int i = 0; i < MER_LEN; i++) tot_reg[i] <= '0;
        end else begin
            wen_reg <= cmd.count_step && stat.mer_ok;
            if (cmd.load) begin
                win_reg  <= {hist_reg, in_base[1:0]};
                ok_reg   <= !in_base[2];
                qcls_reg <= in_class;
            end
            if (wen_reg) begin
                vld_reg[wcls_reg] <= 1'b1;
            end
            if (cmd.count_step && stat.mer_ok) begin
                if (tot_reg[cmd.len] != CMAX) tot_reg[cmd.len] <= tot_reg[cmd.len] + 1'b1;
            end
            if (cmd.count_step && cmd.len == 2'(MER_LEN - 1)) begin
                if (ok_reg) begin
                    hist_reg <= win_reg[HIST_BITS-1:0];
                    if (run_reg < RUN_BITS'(MER_LEN)) run_reg <= run_reg + 1'b1;
                end else begin
                    hist_reg <= '0;
                    run_reg  <= '0;
                end
            end
            if (cmd.clear_step) begin
                vld_reg  <= '0;
                hist_reg <= '0;
                run_reg  <= '0;
                for (int i = 0; i < MER_LEN; i++) tot_reg[i] <= '0;
            end
            if (cmd.read) begin
                inrange_reg <= qcls_reg < CLASS_BITS'(CLASS_COUNT);
                qtot_reg    <= tot_reg[qlen];
                step_reg    <= '0;
            end
            if (cmd.div_step) begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            if (step_reg == '0) begin
                numer_reg <= {rd_reg, {FRAC_W{1'b0}}};
                rem_reg   <= '0;
                quo_reg   <= '0;
            end else begin
                numer_reg <= numer_reg << 1;
                if (!trial[CNT_W] || rem_reg[CNT_W-1]) begin
                    rem_reg <= {1'b0, trial[CNT_W-1:0]};
                    quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[CNT_W-1:0], numer_reg[DIV_STEPS-1]};
                    quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    assign stat.div_done = (step_reg == STEP_BITS'(DIV_STEPS + 1));

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (inrange_reg) begin
                ocnt_reg <= rd_reg;
                otot_reg <= qtot_reg;
                freq_reg <= (qtot_reg == '0) ? '0 : quo_reg[FREQ_W-1:0];
            end else begin
                ocnt_reg <= '0;
                otot_reg <= '0;
                freq_reg <= '0;
            end
        end
    end

    assign frequency    = freq_reg;
    assign class_count  = ocnt_reg;
    assign length_total = otot_reg;

endmodule

>>> design/canonical_kmer_frequency_profile_top.sv
// ----------------------------------------------------------------------------
// canonical_kmer_frequency_profile_top
// canonical k-mer counter for lengths 1 to 4 with frequency query
// ----------------------------------------------------------------------------
// A base word is latched, then takes one step per length bank, as the count
// store takes one read and one write-back per cycle. A clear resets the store
// at once. A query is read and then divided by the restoring divider, one
// quotient bit per cycle over 36 bits. One word is in work at a time; the
// result register lets the next word enter while a result waits.
module canonical_kmer_frequency_profile_top import ckfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // func[1:0], base[4:2], class_index[12:5]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // frequency[16:0], class_count[36:17], length_total[56:37]
);

    ckfp_cmd_t  cmd;
    ckfp_stat_t stat;
    logic [FREQ_W-1:0] freq;
    logic [CNT_W-1:0]  cnt, tot;

    ckfp_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_func(s_tdata[1:0]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .stat, .cmd
    );

    ckfp_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_base(s_tdata[4:2]), .in_class(s_tdata[12:5]),
        .frequency(freq), .class_count(cnt), .length_total(tot)
    );

    assign m_tdata = {7'd0, tot, cnt, freq};

endmodule

>>> design/ckfp_checker.sv
// ----------------------------------------------------------------------------
// ckfp_checker
// port-level checks of the k-mer frequency profile
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ckfp_checker import ckfp_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    `ASSERT_NEXT(a_push_busy, aclk, aresetn, s_tvalid && s_tready && s_tdata[1:0] == FUNC_PUSH, !s_tready)
    `ASSERT_IMPL(a_freq_range, aclk, aresetn, m_tvalid, m_tdata[16:0] <= 17'h10000)
    `ASSERT_IMPL(a_cnt_le_tot, aclk, aresetn, m_tvalid, m_tdata[36:17] <= m_tdata[56:37])
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind canonical_kmer_frequency_profile_top ckfp_checker u_chk (.*);

>>> tb/sv/canonical_kmer_frequency_profile_top_tb.sv
// ----------------------------------------------------------------------------
// canonical_kmer_frequency_profile_top_tb
// self-checking bench: bases, queries and clears are streamed in with random
// gaps and back-pressure, and every query result is checked against a local
// model of the canonical class counts, length totals and Q.16 frequency
// ----------------------------------------------------------------------------
module canonical_kmer_frequency_profile_top_tb;
    import ckfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN    = 4;
    localparam int MAP_SLOTS  = 340;
    localparam int CMAX       = (1 << 20) - 1;
    localparam int STALL_LIMIT = 5000;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [16:0] frequency;
        logic [19:0] class_count;
        logic [19:0] length_total;
    } query_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    canonical_kmer_frequency_profile_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // local copy of the profile
    int            mer_cls [MAP_SLOTS];
    int            len_first [MAX_LEN + 1];
    int unsigned   cls_count [256];
    int unsigned   len_total [MAX_LEN];
    logic [5:0]    hist;
    int            run_len;

    query_result_t pending_results[$];
    int            errors = 0;
    int            words_sent = 0;
    int            results_seen = 0;
    int            queries_sent = 0;
    bit            no_idle = 1'b0;
    bit            hold_off = 1'b0;
    int            quiet_cycles = 0;

    function automatic int mer_rc(int m, int k);
        int r;
        r = 0;
        for (int i = 0; i < k; i++) begin
            r = (r << 2) | (3 - (m & 3));
            m = m >> 2;
        end
        return r;
    endfunction

    function automatic void build_class_map();
        int nxt;
        int off;
        int r;
        nxt = 0;
        for (int k = 1; k <= MAX_LEN; k++) begin
            off = ((1 << (2 * k)) - 4) / 3;
            len_first[k - 1] = nxt;
            for (int m = 0; m < (1 << (2 * k)); m++) begin
                r = mer_rc(m, k);
                if (r < m) begin
                    mer_cls[off + m] = mer_cls[off + r];
                end else begin
                    mer_cls[off + m] = nxt;
                    nxt++;
                end
            end
        end
        len_first[MAX_LEN] = nxt;
    endfunction

    function automatic void clear_profile();
        foreach (cls_count[i]) cls_count[i] = 0;
        foreach (len_total[i]) len_total[i] = 0;
        hist = '0;
        run_len = 0;
    endfunction

    function automatic int unsigned bump(int unsigned v);
        return (v < CMAX) ? v + 1 : v;
    endfunction

    function automatic void profile_word(logic [1:0] func, logic [2:0] base, logic [7:0] idx);
        int            window;
        int            c;
        int            k;
        logic [35:0]   q;
        query_result_t res;
        case (func)
            FUNC_PUSH: begin
                if (base > 3'd3) begin
                    hist = '0;
                    run_len = 0;
                end else begin
                    window = ({26'd0, hist} << 2) | base;
                    for (int l = 1; l <= MAX_LEN; l++) begin
                        if (run_len + 1 >= l) begin
                            c = mer_cls[((1 << (2 * l)) - 4) / 3 +
                                        (window & ((1 << (2 * l)) - 1))];
                            cls_count[c] = bump(cls_count[c]);
                            len_total[l - 1] = bump(len_total[l - 1]);
                        end
                    end
                    hist = window[5:0];
                    if (run_len < MAX_LEN) run_len++;
                end
            end
            FUNC_QUERY: begin
                res = '0;
                if (idx < len_first[MAX_LEN]) begin
                    k = 1;
                    while (k < MAX_LEN && idx >= len_first[k]) k++;
                    res.class_count  = 20'(cls_count[idx]);
                    res.length_total = 20'(len_total[k - 1]);
                    if (len_total[k - 1] != 0) begin
                        q = ({16'd0, res.class_count} << 16) / res.length_total;
                        res.frequency = q[16:0];
                    end
                end
                pending_results.insert(pending_results.size(), res);
            end
            FUNC_CLEAR: clear_profile();
            default: ;
        endcase
    endfunction

    // sends one word, gaps chosen at random unless idling is off
    task automatic send_word(logic [1:0] func, logic [2:0] base, logic [7:0] idx);
        if (!no_idle) begin
            while ($urandom_range(99) < 25) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, idx, base, func};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        profile_word(func, base, idx);
        words_sent++;
        if (func == FUNC_QUERY) queries_sent++;
        @(negedge aclk);
    endtask

    task automatic push_base(logic [2:0] b);
        send_word(FUNC_PUSH, b, 8'($urandom_range(255)));
    endtask

    task automatic query_class(logic [7:0] idx);
        send_word(FUNC_QUERY, 3'($urandom_range(7)), idx);
    endtask

    // stop offering and wait for every expected result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // receiver side
    always @(negedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 25);
        end
    end

    always @(posedge aclk) begin
        query_result_t got;
        query_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[56:37], m_tdata[36:17], m_tdata[16:0]} == 0 ? '0 :
                  query_result_t'({m_tdata[16:0], m_tdata[36:17], m_tdata[56:37]});
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.frequency !== want.frequency) begin
                    $error("frequency expected %0d got %0d", want.frequency, got.frequency);
                    errors++;
                end
                if (got.class_count !== want.class_count) begin
                    $error("class_count expected %0d got %0d",
                           want.class_count, got.class_count);
                    errors++;
                end
                if (got.length_total !== want.length_total) begin
                    $error("length_total expected %0d got %0d",
                           want.length_total, got.length_total);
                    errors++;
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic test_directed();
        query_class(8'd0);
        push_base(3'd0);
        push_base(3'd1);
        push_base(3'd2);
        push_base(3'd3);
        push_base(3'd3);
        query_class(8'd0);
        query_class(8'd1);
        query_class(8'd2);
        query_class(8'd43);
        push_base(3'd4);
        push_base(3'd1);
        push_base(3'd7);
        push_base(3'd2);
        query_class(8'd179);
        query_class(8'd178);
        query_class(8'd180);
        query_class(8'd255);
        send_word(FUNC_SPARE, 3'd5, 8'd170);
        send_word(FUNC_CLEAR, 3'd6, 8'd85);
        query_class(8'd1);
        push_base(3'd6);
        push_base(3'd5);
        query_class(8'd44);
        drain();
    endtask

    task automatic test_random_segments(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) no_idle = 1'b1;
            if (i == n / 2 + 120) no_idle = 1'b0;
            r = $urandom_range(99);
            if (r < 78) begin
                push_base(($urandom_range(99) < 6) ? 3'($urandom_range(7, 4))
                                                   : 3'($urandom_range(3)));
            end else if (r < 95) begin
                query_class(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                     : 8'($urandom_range(179)));
            end else if (r < 97) begin
                send_word(FUNC_SPARE, 3'($urandom_range(7)), 8'($urandom_range(255)));
            end else if (r < 98) begin
                send_word(FUNC_CLEAR, 3'($urandom_range(7)), 8'($urandom_range(255)));
            end else begin
                push_base(3'($urandom_range(3)));
            end
        end
    endtask

    task automatic test_back_pressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++) begin
                    push_base(3'($urandom_range(3)));
                    query_class(8'($urandom_range(179)));
                end
            end
        join
        drain();
    endtask

    initial begin
        build_class_map();
        clear_profile();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_segments(860);
        test_back_pressure();

        drain();
        repeat (100) @(posedge aclk);
        $display("run covered %0d words with %0d queries, %0d results checked",
                 words_sent, queries_sent, results_seen);
        $display("including other symbols, clears, spare codes and a long receiver stall");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
